/* src/porq_pkg.sv */
// Package for the priority-ordered ready queue: payload structs, controller
// state, datapath command and status types, and default sizes. No dependencies.
`default_nettype none

package porq_pkg;

  localparam int unsigned QueueDepthDef   = 16;
  localparam int unsigned PriorityBitsDef = 8;

  localparam int unsigned IdW    = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned CountW = 5;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModePop    = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [IdW-1:0]   task_id;
    logic [PrioW-1:0] task_priority;
  } porq_in_t;

  typedef struct packed {
    logic              popped_valid;
    logic [IdW-1:0]    popped_id;
    logic [PrioW-1:0]  popped_priority;
    logic [CountW-1:0] entry_count;
    logic              insert_dropped;
  } porq_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP_TAKE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_RESULT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_TAIL,
    RD_PREV
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_SHIFT,
    WR_NEW_NEXT,
    WR_NEW_HEAD
  } wr_sel_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_EMPTY,
    RES_DROP,
    RES_POP,
    RES_INS
  } res_sel_e;

  typedef struct packed {
    logic     ld_in;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     idx_load;
    logic     idx_dec;
    res_sel_e res_sel;
    logic     out_ld;
  } porq_cmd_t;

  typedef struct packed {
    logic mode;
    logic occ_zero;
    logic occ_full;
    logic idx_zero;
    logic shift;
    logic out_free;
  } porq_sts_t;

endpackage

`default_nettype wire

/* src/porq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module porq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/porq_ctrl.sv */
// Controller for the ready queue: sequences decode, tail-first insert scan,
// pop and result hand-off. Depends on porq_pkg.
`default_nettype none

module porq_ctrl import porq_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire porq_sts_t sts_i,
  output porq_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.rd_sel   = RD_HEAD;
    cmd_o.wr_sel   = WR_NEW_HEAD;
    cmd_o.res_sel  = RES_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.mode == ModePop) begin
          if (sts_i.occ_zero) begin
            cmd_o.res_sel = RES_EMPTY;
            state_d       = ST_RESULT;
          end else begin
            cmd_o.rd_sel = RD_HEAD;
            state_d      = ST_POP_TAKE;
          end
        end else begin
          priority if (sts_i.occ_full) begin
            cmd_o.res_sel = RES_DROP;
            state_d       = ST_RESULT;
          end else if (sts_i.occ_zero) begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_sel  = WR_NEW_HEAD;
            cmd_o.res_sel = RES_INS;
            state_d       = ST_RESULT;
          end else begin
            cmd_o.idx_load = 1'b1;
            cmd_o.rd_sel   = RD_TAIL;
            state_d        = ST_INS_CMP;
          end
        end
      end
      ST_POP_TAKE: begin
        cmd_o.res_sel = RES_POP;
        state_d       = ST_RESULT;
      end
      ST_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.shift) begin
          cmd_o.wr_sel = WR_SHIFT;
          if (sts_i.idx_zero) begin
            state_d = ST_INS_PUT;
          end else begin
            cmd_o.idx_dec = 1'b1;
            cmd_o.rd_sel  = RD_PREV;
          end
        end else begin
          cmd_o.wr_sel  = WR_NEW_NEXT;
          cmd_o.res_sel = RES_INS;
          state_d       = ST_RESULT;
        end
      end
      ST_INS_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_NEW_HEAD;
        cmd_o.res_sel = RES_INS;
        state_d       = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/porq_dp.sv */
// Datapath for the ready queue: circular entry store, head and count, scan
// index, result staging and output register. Depends on porq_pkg, porq_ram.
`default_nettype none

module porq_dp import porq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = QueueDepthDef,
  parameter int unsigned PRIORITY_BITS = PriorityBitsDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire porq_in_t  in_data_i,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output porq_out_t      out_data_o,
  input  wire porq_cmd_t cmd_i,
  output porq_sts_t      sts_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = (PRIORITY_BITS < PrioW) ? PRIORITY_BITS : PrioW;
  localparam int unsigned EW = IdW + PW;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW:0] ofs);
    logic [AW+1:0] sum;
    sum = {2'b00, base} + {1'b0, ofs};
    if (sum >= (AW+2)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+2)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  porq_in_t      in_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [AW-1:0] idx_q, idx_d;
  porq_out_t     res_q, res_d;
  porq_out_t     out_q;
  logic          out_valid_q, out_valid_d;

  logic [PW-1:0] new_prio;
  logic [AW:0]   rd_ofs, wr_ofs;
  logic [AW-1:0] raddr, waddr;
  logic [EW-1:0] wdata, rdata;
  logic [PW-1:0] rd_prio;
  logic [IdW-1:0] rd_id;

  assign new_prio = in_q.task_priority[PW-1:0];
  assign rd_id    = rdata[EW-1:PW];
  assign rd_prio  = rdata[PW-1:0];

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_HEAD: rd_ofs = '0;
      RD_TAIL: rd_ofs = (AW+1)'(occ_q - CW'(1));
      RD_PREV: rd_ofs = (idx_q == '0) ? '0 : {1'b0, idx_q - AW'(1)};
      default: rd_ofs = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_SHIFT: begin
        wr_ofs = {1'b0, idx_q} + (AW+1)'(1);
        wdata  = rdata;
      end
      WR_NEW_NEXT: begin
        wr_ofs = {1'b0, idx_q} + (AW+1)'(1);
        wdata  = {in_q.task_id, new_prio};
      end
      WR_NEW_HEAD: begin
        wr_ofs = '0;
        wdata  = {in_q.task_id, new_prio};
      end
      default: begin
        wr_ofs = '0;
        wdata  = {in_q.task_id, new_prio};
      end
    endcase
  end

  assign raddr = phys(head_q, rd_ofs);
  assign waddr = phys(head_q, wr_ofs);

  porq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_load) begin
      idx_d = AW'(occ_q - CW'(1));
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - AW'(1);
    end
  end

  always_comb begin
    head_d = head_q;
    occ_d  = occ_q;
    res_d  = res_q;
    unique case (cmd_i.res_sel)
      RES_NONE: begin
      end
      RES_EMPTY: begin
        res_d             = '0;
        res_d.entry_count = CountW'(occ_q);
      end
      RES_DROP: begin
        res_d                = '0;
        res_d.entry_count    = CountW'(occ_q);
        res_d.insert_dropped = 1'b1;
      end
      RES_POP: begin
        occ_d                 = occ_q - CW'(1);
        head_d                = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
        res_d                 = '0;
        res_d.popped_valid    = 1'b1;
        res_d.popped_id       = rd_id;
        res_d.popped_priority = PrioW'(rd_prio);
        res_d.entry_count     = CountW'(occ_d);
      end
      RES_INS: begin
        occ_d             = occ_q + CW'(1);
        res_d             = '0;
        res_d.entry_count = CountW'(occ_d);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      in_q <= in_data_i;
    end
    idx_q <= idx_d;
    res_q <= res_d;
    if (cmd_i.out_ld) begin
      out_q <= res_q;
    end
  end

  assign sts_o.mode     = in_q.mode;
  assign sts_o.occ_zero = (occ_q == '0);
  assign sts_o.occ_full = (occ_q == CW'(QUEUE_DEPTH));
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.shift    = (rd_prio < new_prio);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != $past(occ_q)) |->
      ((occ_q == $past(occ_q) + CW'(1)) || (occ_q == $past(occ_q) - CW'(1))))
    else $error("entry count moved by more than one");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res_sel == RES_POP) |-> (occ_q != '0))
    else $error("pop committed on empty queue");

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res_sel == RES_INS) |-> (occ_q != CW'(QUEUE_DEPTH)))
    else $error("insert committed on full queue");

  a_idx_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.idx_dec |-> (idx_q != '0))
    else $error("scan index stepped below head");

endmodule

`default_nettype wire

/* src/priority_ordered_ready_queue_unit.sv */
// Top level of the priority-ordered ready queue: joins controller and datapath.
// Depends on porq_pkg, porq_ctrl, porq_dp.
//
// Holds up to QUEUE_DEPTH tasks (id plus priority) in descending priority
// order; equal priorities leave first-in first-out.
// Input channel (in_valid_i/in_ready_o, in_data_i): mode selects insert or
// pop. Output channel (out_valid_o/out_ready_i, out_data_o): one result beat
// per input beat, carrying the popped task, the count after the operation and
// the drop flag for an insert into a full queue.
// One operation runs at a time; in_ready_o is high only while idle.
// The insert walks the stored entries from the tail toward the head, one
// entry per cycle through the single read port of the entry RAM, moving each
// lower-priority entry up one slot. A new beat can be taken in the cycle
// after the result is loaded into the output register.
// Reset empties the queue at once; the entry RAM needs no clearing.
// When the receiver stalls, the result waits in the output register and the
// next operation runs up to its result stage, then holds.
`default_nettype none

module priority_ordered_ready_queue_unit import porq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = QueueDepthDef,
  parameter int unsigned PRIORITY_BITS = PriorityBitsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire porq_in_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output porq_out_t     out_data_o
);

  porq_cmd_t cmd;
  porq_sts_t sts;

  porq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  porq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire

/* sim/priority_ordered_ready_queue_unit_tb.sv */
// Testbench for priority_ordered_ready_queue_unit: directed table, then random insert/pop
// phases, most with random idling on both channels; each result is checked against the table
// row's expected result or a queue predictor. Depends on porq_pkg and the RTL under src.
`default_nettype none

module priority_ordered_ready_queue_unit_tb;
  import porq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [PrioW-1:0] PrioMask = PrioW'((64'd1 << PriorityBitsDef) - 1);

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } ready_task_t;

  typedef struct {
    porq_in_t  beat;
    logic      known;
    porq_out_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  porq_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  porq_out_t out_data;

  ready_task_t ready_list[$];
  porq_out_t   due_results[$];
  int          errors = 0;
  logic        idle_on = 1'b1;
  logic        hold_results = 1'b0;

  dir_row_t directed_rows[25] = '{
    '{{ModePop,    16'h0000, 8'h00}, 1'b1, {1'b0, 16'h0000, 8'h00, 5'd0, 1'b0}},
    '{{ModeInsert, 16'hFFFF, 8'h00}, 1'b1, {1'b0, 16'h0000, 8'h00, 5'd1, 1'b0}},
    '{{ModeInsert, 16'h0000, 8'hFF}, 1'b1, {1'b0, 16'h0000, 8'h00, 5'd2, 1'b0}},
    '{{ModePop,    16'h0000, 8'h00}, 1'b1, {1'b1, 16'h0000, 8'hFF, 5'd1, 1'b0}},
    '{{ModeInsert, 16'h1234, 8'h00}, 1'b1, {1'b0, 16'h0000, 8'h00, 5'd2, 1'b0}},
    '{{ModePop,    16'h0000, 8'h00}, 1'b1, {1'b1, 16'hFFFF, 8'h00, 5'd1, 1'b0}},
    '{{ModePop,    16'h0000, 8'h00}, 1'b1, {1'b1, 16'h1234, 8'h00, 5'd0, 1'b0}},
    '{{ModePop,    16'hFFFF, 8'hFF}, 1'b1, {1'b0, 16'h0000, 8'h00, 5'd0, 1'b0}},
    '{{ModeInsert, 16'hA001, 8'hFF}, 1'b0, '0},
    '{{ModeInsert, 16'hA002, 8'h00}, 1'b0, '0},
    '{{ModeInsert, 16'hA003, 8'h80}, 1'b0, '0},
    '{{ModeInsert, 16'hA004, 8'h80}, 1'b0, '0},
    '{{ModeInsert, 16'hA005, 8'h7F}, 1'b0, '0},
    '{{ModeInsert, 16'hA006, 8'h01}, 1'b0, '0},
    '{{ModeInsert, 16'hA007, 8'hFE}, 1'b0, '0},
    '{{ModeInsert, 16'hA008, 8'h80}, 1'b0, '0},
    '{{ModeInsert, 16'h5555, 8'h00}, 1'b0, '0},
    '{{ModeInsert, 16'hAAAA, 8'hFF}, 1'b0, '0},
    '{{ModeInsert, 16'hA00B, 8'h40}, 1'b0, '0},
    '{{ModeInsert, 16'hA00C, 8'h40}, 1'b0, '0},
    '{{ModeInsert, 16'hA00D, 8'hC0}, 1'b0, '0},
    '{{ModeInsert, 16'hA00E, 8'h10}, 1'b0, '0},
    '{{ModeInsert, 16'hA00F, 8'h80}, 1'b0, '0},
    '{{ModeInsert, 16'hA010, 8'h20}, 1'b0, '0},
    '{{ModeInsert, 16'h5A5A, 8'hFF}, 1'b1, {1'b0, 16'h0000, 8'h00, 5'd16, 1'b1}}
  };

  priority_ordered_ready_queue_unit #(
    .QUEUE_DEPTH  (QueueDepthDef),
    .PRIORITY_BITS(PriorityBitsDef)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  function automatic porq_out_t apply_queue_op(porq_in_t b);
    porq_out_t   r;
    ready_task_t t;
    int          pos;
    r = '0;
    if (b.mode == ModePop) begin
      if (ready_list.size() != 0) begin
        t = ready_list.pop_front();
        r.popped_valid    = 1'b1;
        r.popped_id       = t.id;
        r.popped_priority = t.prio;
      end
    end else if (ready_list.size() >= QueueDepthDef) begin
      r.insert_dropped = 1'b1;
    end else begin
      t.id   = b.task_id;
      t.prio = b.task_priority & PrioMask;
      pos = ready_list.size();
      for (int i = ready_list.size() - 1; i >= 0; i--)
        if (t.prio > ready_list[i].prio) pos = i;
      ready_list.insert(pos, t);
    end
    r.entry_count = CountW'(ready_list.size());
    return r;
  endfunction

  task automatic send_beat(porq_in_t b, logic known, porq_out_t want);
    int        gap;
    porq_out_t pred;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = apply_queue_op(b);
    due_results.push_back(known ? want : pred);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : result_sink
    int        stall;
    porq_out_t want;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (hold_results) begin
        stall = 120;
        hold_results = 1'b0;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (due_results.size() == 0) begin
        $display("%0t: result beat with nothing due, got %h", $time, out_data);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("popped_valid", want.popped_valid, out_data.popped_valid);
        check_field("popped_id", want.popped_id, out_data.popped_id);
        check_field("popped_priority", want.popped_priority, out_data.popped_priority);
        check_field("entry_count", want.entry_count, out_data.entry_count);
        check_field("insert_dropped", want.insert_dropped, out_data.insert_dropped);
      end
    end
  end

  initial begin : stimulus
    porq_in_t b;
    int       ins_pct;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r])
      send_beat(directed_rows[r].beat, directed_rows[r].known, directed_rows[r].want);

    for (int ph = 0; ph < 11; ph++) begin
      idle_on = !(ph == 3 || ph == 8);
      ins_pct = (ph % 3 == 0) ? 80 : (ph % 3 == 1) ? 50 : 25;
      if (ph == 3) hold_results = 1'b1;
      if (ph == 6) begin
        idle_input();
        wait (due_results.size() == 0);
      end
      for (int k = 0; k < 39; k++) begin
        b.mode          = ($urandom_range(0, 99) < ins_pct) ? ModeInsert : ModePop;
        b.task_id       = IdW'($urandom);
        b.task_priority = (ph % 2 == 1) ? PrioW'($urandom_range(126, 129))
                                        : PrioW'($urandom);
        send_beat(b, 1'b0, '0);
      end
    end

    idle_input();
    wait (due_results.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
src/porq_pkg.sv
src/porq_ram.sv
src/porq_ctrl.sv
src/porq_dp.sv
src/priority_ordered_ready_queue_unit.sv
sim/priority_ordered_ready_queue_unit_tb.sv
